>>> src/blta_pkg.sv
// ---------------------------------------------------------------------------
// blta_pkg
// Shared constants for the block-linear texture address generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blta_pkg;

    // Field widths
    localparam int DIM_W  = 13;    // pixel coordinate / texture size
    localparam int OFS_W  = 28;    // byte offsets
    localparam int PIX_W  = 26;    // pixel index inside the buffer

    // Layout geometry (RGBA8: 4 bytes per pixel)
    localparam int BLOCK_PIX      = 16;   // pixels per 64-byte line
    localparam int LINE_ROWS      = 8;    // rows per 512-byte group
    localparam int MAX_BLK_GROUPS = 16;   // block height cap in groups of 8 rows

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] TEX_WIDTH_RST  = 13'd1024;
    localparam logic [DIM_W-1:0] TEX_HEIGHT_RST = 13'd1024;

    // Permutation of the 16-byte units inside each 512-byte group
    localparam logic [4:0] UNIT_SWAP [32] = '{
        5'd0,  5'd2,  5'd16, 5'd18,
        5'd1,  5'd3,  5'd17, 5'd19,
        5'd4,  5'd6,  5'd20, 5'd22,
        5'd5,  5'd7,  5'd21, 5'd23,
        5'd8,  5'd10, 5'd24, 5'd26,
        5'd9,  5'd11, 5'd25, 5'd27,
        5'd12, 5'd14, 5'd28, 5'd30,
        5'd13, 5'd15, 5'd29, 5'd31
    };

endpackage : blta_pkg

`default_nettype wire

>>> src/block_linear_texture_address.sv
// An accepted request passes the stage 1, 2 and 3 registers into the output register.
// Throughput: one request per cycle when not stalled; four register stages (size checks,
// two multiplier stages, unit permutation) each advance independently on stall.
// Reset (rst_n low, asynchronous): pipeline empties, tex_width and tex_height
// return to 1024. Configuration writes are always accepted (cfg_ready tied high).
// ---------------------------------------------------------------------------
// block_linear_texture_address
// Maps a linear pixel position of an RGBA8 texture to its byte offset in
// the block-linear tiled layout and in the linear layout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module block_linear_texture_address
    import blta_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    // configuration write channel
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [DIM_W-1:0]      cfg_data,
    // request channel
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire [DIM_W-1:0]      pix_x,
    input  wire [DIM_W-1:0]      pix_y,
    // result channel
    output logic                 out_valid,
    input  wire                  out_stall,
    output logic [OFS_W-1:0]     tiled_offset,
    output logic [OFS_W-1:0]     linear_offset,
    output logic                 in_range
);

    // -----------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------
    logic [DIM_W-1:0] tex_width_reg;
    logic [DIM_W-1:0] tex_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= TEX_WIDTH_RST;
            tex_height_reg <= TEX_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TEX_WIDTH:  tex_width_reg  <= cfg_data;
                REG_TEX_HEIGHT: tex_height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // -----------------------------------------------------------------
    // Stage advance chain: a stage moves when empty or when the next moves
    // -----------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic adv1, adv2, adv3, advo;

    assign advo     = !vo_reg || !out_stall;
    assign adv3     = !v3_reg || advo;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (advo) vo_reg <= v3_reg;
        end
    end

    // -----------------------------------------------------------------
    // Stage 1: rounded sizes, block height, range check
    // -----------------------------------------------------------------
    logic [DIM_W:0]   w_sum;
    logic [DIM_W:0]   h_sum;
    logic [9:0]       outw_next;     // width in blocks
    logic [DIM_W:0]   w_full;
    logic [10:0]      h8;            // height in groups of 8 rows
    logic             tall;          // block height capped
    logic [DIM_W:0]   rows;          // rows covered by whole blocks
    logic [4:0]       groups_next;
    logic             ok1_next;

    always_comb
    begin
        w_sum     = {1'b0, tex_width_reg} + (DIM_W+1)'(BLOCK_PIX - 1);
        h_sum     = {1'b0, tex_height_reg} + (DIM_W+1)'(LINE_ROWS - 1);
        outw_next = w_sum[DIM_W:4];
        w_full    = {outw_next, 4'b0000};
        h8        = h_sum[DIM_W:3];
        tall      = (h8 >= 11'(MAX_BLK_GROUPS));
        if (tall)
        begin
            rows        = {h8[10:4], 7'b0000000};
            groups_next = 5'(MAX_BLK_GROUPS);
        end
        else
        begin
            // whole texture is one block row
            rows        = {h8, 3'b000};
            groups_next = (h8 == 11'd0) ? 5'd1 : {1'b0, h8[3:0]};
        end
        ok1_next = ({1'b0, pix_x} < w_full) && ({1'b0, pix_y} < rows);
    end

    logic [DIM_W-1:0] x1_reg, y1_reg;
    logic [9:0]       outw1_reg;
    logic [4:0]       groups1_reg;
    logic             ok1_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            x1_reg      <= pix_x;
            y1_reg      <= pix_y;
            outw1_reg   <= outw_next;
            groups1_reg <= groups_next;
            ok1_reg     <= ok1_next;
        end
    end

    // -----------------------------------------------------------------
    // Stage 2: block-row times width, row times width
    // -----------------------------------------------------------------
    logic [15:0] m_blk_next;
    logic [22:0] m_lin_next;

    assign m_blk_next = 16'(y1_reg[12:7]) * 16'(outw1_reg);
    assign m_lin_next = 23'(y1_reg) * 23'(outw1_reg);

    logic [15:0]      m_blk2_reg;
    logic [22:0]      m_lin2_reg;
    logic [DIM_W-1:0] x2_reg;
    logic [6:0]       row2_reg;
    logic [4:0]       groups2_reg;
    logic             ok2_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            m_blk2_reg  <= m_blk_next;
            m_lin2_reg  <= m_lin_next;
            x2_reg      <= x1_reg;
            row2_reg    <= y1_reg[6:0];
            groups2_reg <= groups1_reg;
            ok2_reg     <= ok1_reg;
        end
    end

    // -----------------------------------------------------------------
    // Stage 3: block index times block height, linear pixel index
    // -----------------------------------------------------------------
    logic [16:0]      blk_idx;
    logic [20:0]      blk_prod_next;
    logic [PIX_W-1:0] lin_pix_next;

    always_comb
    begin
        blk_idx       = {1'b0, m_blk2_reg} + 17'(x2_reg[12:4]);
        blk_prod_next = 21'(blk_idx) * 21'(groups2_reg);
        lin_pix_next  = PIX_W'({m_lin2_reg, 4'b0000}) + PIX_W'(x2_reg);
    end

    logic [20:0]      blk_prod3_reg;
    logic [PIX_W-1:0] lin_pix3_reg;
    logic [6:0]       row3_reg;
    logic [3:0]       xi3_reg;
    logic             ok3_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            blk_prod3_reg <= blk_prod_next;
            lin_pix3_reg  <= lin_pix_next;
            row3_reg      <= row2_reg;
            xi3_reg       <= x2_reg[3:0];
            ok3_reg       <= ok2_reg;
        end
    end

    // -----------------------------------------------------------------
    // Stage 4: tiled pixel index, unit permutation, output register
    // -----------------------------------------------------------------
    logic [OFS_W-1:0] pix_wide;
    logic [OFS_W-1:0] t_ofs;
    logic [OFS_W-1:0] tiled_next;
    logic [OFS_W-1:0] lin_next;

    always_comb
    begin
        // block base is blk_prod * 8 rows * 16 pixels
        pix_wide   = {blk_prod3_reg, 7'b0000000}
                   + OFS_W'({row3_reg, xi3_reg});
        t_ofs      = {pix_wide[PIX_W-1:0], 2'b00};
        tiled_next = {t_ofs[OFS_W-1:9], UNIT_SWAP[t_ofs[8:4]], t_ofs[3:0]};
        lin_next   = {lin_pix3_reg, 2'b00};
        if (!ok3_reg)
        begin
            tiled_next = '0;
            lin_next   = '0;
        end
    end

    logic [OFS_W-1:0] tiled_reg;
    logic [OFS_W-1:0] linear_reg;
    logic             range_reg;

    always_ff @(posedge clk)
    begin
        if (advo)
        begin
            tiled_reg  <= tiled_next;
            linear_reg <= lin_next;
            range_reg  <= ok3_reg;
        end
    end

    assign out_valid     = vo_reg;
    assign tiled_offset  = tiled_reg;
    assign linear_offset = linear_reg;
    assign in_range      = range_reg;

`ifndef SYNTH
    // Out-of-range results carry zero offsets
    assert property (@(posedge clk) disable iff (!rst_n)
        (vo_reg && !range_reg) |-> (tiled_reg == '0 && linear_reg == '0))
        else $error("out-of-range result with nonzero offset");

    // Both offsets are pixel aligned
    assert property (@(posedge clk) disable iff (!rst_n)
        vo_reg |-> (tiled_reg[1:0] == 2'b00 && linear_reg[1:0] == 2'b00))
        else $error("offset not aligned to a pixel");

    // Input is held off only when the first stage holds a request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg)
        else $error("input stalled with empty first stage");

    // A stalled result stays on the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (vo_reg && out_stall) |=> (vo_reg && $stable(tiled_reg) && $stable(linear_reg)))
        else $error("stalled result lost or changed");
`endif

endmodule : block_linear_texture_address

`default_nettype wire
